### hw/rtl/gamepad_report_event_generator_unit_assert.svh
// ---------------------------------------------------------------------------
// gamepad report event generator assertion macros
// shared property forms for the port checker
// ---------------------------------------------------------------------------
`ifndef GAMEPAD_REPORT_EVENT_GENERATOR_UNIT_ASSERT_SVH
`define GAMEPAD_REPORT_EVENT_GENERATOR_UNIT_ASSERT_SVH

// same-cycle implication, held off during reset
`define GREG_ASSERT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gamepad event check failed");

// next-cycle implication, held off during reset
`define GREG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gamepad event check failed");

`endif

### hw/rtl/greg_pkg.sv
// ---------------------------------------------------------------------------
// greg_pkg
// shared types and constants of the gamepad report event generator
// ---------------------------------------------------------------------------
package greg_pkg;

    localparam int NUM_SLOTS = 16;

    // reset values of the stick registers
    localparam logic [7:0] CENTER_RESET   = 8'h7F;
    localparam logic [6:0] DEADBAND_RESET = 7'h25;
    localparam logic [2:0] CODE_LEFT_RESET  = 3'd6;
    localparam logic [2:0] CODE_RIGHT_RESET = 3'd2;
    localparam logic [2:0] CODE_UP_RESET    = 3'd0;
    localparam logic [2:0] CODE_DOWN_RESET  = 3'd4;

    // event slot positions inside one report
    localparam int SLOT_START    = 0;
    localparam int SLOT_FACE     = 2;
    localparam int SLOT_SHOULDER = 6;
    localparam int SLOT_HAT_REL  = 10;
    localparam int SLOT_HAT_PRS  = 11;
    localparam int SLOT_AXIS     = 12;

    // first button numbers of each group
    localparam int CODE_START    = 9;
    localparam int CODE_FACE     = 1;
    localparam int CODE_SHOULDER = 5;

    typedef enum logic [1:0] {
        KIND_BTN_DOWN = 2'd0,
        KIND_BTN_UP   = 2'd1,
        KIND_DIR_DOWN = 2'd2,
        KIND_DIR_UP   = 2'd3
    } ev_kind_t;

    typedef enum logic [2:0] {
        CFG_CENTER     = 3'd0,
        CFG_DEADBAND   = 3'd1,
        CFG_CODE_LEFT  = 3'd2,
        CFG_CODE_RIGHT = 3'd3,
        CFG_CODE_UP    = 3'd4,
        CFG_CODE_DOWN  = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0] center;
        logic [6:0] deadband;
        logic [2:0] code_left;
        logic [2:0] code_right;
        logic [2:0] code_up;
        logic [2:0] code_down;
    } cfg_t;

    typedef struct packed {
        ev_kind_t   kind;
        logic [3:0] code;
    } ev_t;

    // one classified report: a mask of live slots and each slot's event
    typedef struct packed {
        logic [NUM_SLOTS-1:0]      mask;
        ev_t  [NUM_SLOTS-1:0]      ev;
    } job_t;

endpackage

### hw/rtl/greg_front.sv
// ---------------------------------------------------------------------------
// greg_front
// compares a report with the previous one and builds its event slots
// ---------------------------------------------------------------------------
module greg_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  greg_pkg::cfg_t       cfg,
    input  logic                 accept,
    input  logic [7:0]           axis_x,
    input  logic [7:0]           axis_y,
    input  logic [3:0]           hat_value,
    input  logic [3:0]           face_bits,
    input  logic [3:0]           shoulder_bits,
    input  logic [1:0]           start_bits,
    output greg_pkg::job_t       job,
    output logic                 job_push
);

    logic [1:0] prev_start_reg;
    logic [3:0] prev_face_reg;
    logic [3:0] prev_shoulder_reg;
    logic [3:0] prev_hat_reg;
    logic       prev_hat_vld_reg;
    logic [3:0] latch_reg;
    logic [3:0] latch_next;

    logic              hat_diff;
    logic [7:0]        axis_val [2];
    logic [2:0]        code_lo  [2];
    logic [2:0]        code_hi  [2];
    logic signed [9:0] lo_bound;
    logic signed [9:0] hi_bound;
    logic [1:0]        below;
    logic [1:0]        above;

    assign axis_val[0] = axis_x;
    assign axis_val[1] = axis_y;
    assign code_lo[0]  = cfg.code_left;
    assign code_hi[0]  = cfg.code_right;
    assign code_lo[1]  = cfg.code_up;
    assign code_hi[1]  = cfg.code_down;

    // signed bounds, so a zone edge past 0 or 255 never triggers
    assign lo_bound = $signed({2'b00, cfg.center}) - $signed({3'b000, cfg.deadband});
    assign hi_bound = $signed({2'b00, cfg.center}) + $signed({3'b000, cfg.deadband});

    assign hat_diff = !prev_hat_vld_reg || (prev_hat_reg != hat_value);

    always_comb
    begin
        job        = '0;
        latch_next = latch_reg;
        below      = '0;
        above      = '0;

        for (int i = 0; i < 2; i++)
        begin
            job.mask[greg_pkg::SLOT_START + i] = start_bits[i] ^ prev_start_reg[i];
            job.ev[greg_pkg::SLOT_START + i].kind =
                start_bits[i] ? greg_pkg::KIND_BTN_DOWN : greg_pkg::KIND_BTN_UP;
            job.ev[greg_pkg::SLOT_START + i].code = 4'(greg_pkg::CODE_START + i);
        end

        for (int i = 0; i < 4; i++)
        begin
            job.mask[greg_pkg::SLOT_FACE + i] = face_bits[i] ^ prev_face_reg[i];
            job.ev[greg_pkg::SLOT_FACE + i].kind =
                face_bits[i] ? greg_pkg::KIND_BTN_DOWN : greg_pkg::KIND_BTN_UP;
            job.ev[greg_pkg::SLOT_FACE + i].code = 4'(greg_pkg::CODE_FACE + i);

            job.mask[greg_pkg::SLOT_SHOULDER + i] = shoulder_bits[i] ^ prev_shoulder_reg[i];
            job.ev[greg_pkg::SLOT_SHOULDER + i].kind =
                shoulder_bits[i] ? greg_pkg::KIND_BTN_DOWN : greg_pkg::KIND_BTN_UP;
            job.ev[greg_pkg::SLOT_SHOULDER + i].code = 4'(greg_pkg::CODE_SHOULDER + i);
        end

        // hat: only directions 0-7 give events
        job.mask[greg_pkg::SLOT_HAT_REL] = hat_diff && prev_hat_vld_reg && !prev_hat_reg[3];
        job.ev[greg_pkg::SLOT_HAT_REL].kind = greg_pkg::KIND_DIR_UP;
        job.ev[greg_pkg::SLOT_HAT_REL].code = {1'b0, prev_hat_reg[2:0]};
        job.mask[greg_pkg::SLOT_HAT_PRS] = hat_diff && !hat_value[3];
        job.ev[greg_pkg::SLOT_HAT_PRS].kind = greg_pkg::KIND_DIR_DOWN;
        job.ev[greg_pkg::SLOT_HAT_PRS].code = {1'b0, hat_value[2:0]};

        for (int a = 0; a < 2; a++)
        begin
            below[a] = $signed({2'b00, axis_val[a]}) < lo_bound;
            above[a] = $signed({2'b00, axis_val[a]}) > hi_bound;

            job.mask[greg_pkg::SLOT_AXIS + 2*a] =
                (below[a] && !latch_reg[2*a]) || (!below[a] && !above[a] && latch_reg[2*a]);
            job.ev[greg_pkg::SLOT_AXIS + 2*a].kind =
                below[a] ? greg_pkg::KIND_DIR_DOWN : greg_pkg::KIND_DIR_UP;
            job.ev[greg_pkg::SLOT_AXIS + 2*a].code = {1'b0, code_lo[a]};

            job.mask[greg_pkg::SLOT_AXIS + 2*a + 1] =
                (above[a] && !latch_reg[2*a+1]) ||
                (!below[a] && !above[a] && latch_reg[2*a+1]);
            job.ev[greg_pkg::SLOT_AXIS + 2*a + 1].kind =
                above[a] ? greg_pkg::KIND_DIR_DOWN : greg_pkg::KIND_DIR_UP;
            job.ev[greg_pkg::SLOT_AXIS + 2*a + 1].code = {1'b0, code_hi[a]};

            // opposite latch is kept while the stick is out of the zone
            latch_next[2*a]   = below[a] || (above[a] && latch_reg[2*a]);
            latch_next[2*a+1] = above[a] || (below[a] && latch_reg[2*a+1]);
        end
    end

    assign job_push = accept && (|job.mask);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_start_reg    <= '0;
            prev_face_reg     <= '0;
            prev_shoulder_reg <= '0;
            prev_hat_reg      <= '0;
            prev_hat_vld_reg  <= 1'b0;
            latch_reg         <= '0;
        end
        else if (accept)
        begin
            prev_start_reg    <= start_bits;
            prev_face_reg     <= face_bits;
            prev_shoulder_reg <= shoulder_bits;
            prev_hat_reg      <= hat_value;
            prev_hat_vld_reg  <= 1'b1;
            latch_reg         <= latch_next;
        end
    end

endmodule

### hw/rtl/greg_job_queue.sv
// ---------------------------------------------------------------------------
// greg_job_queue
// two-entry queue of classified reports between front and back
// ---------------------------------------------------------------------------
module greg_job_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  greg_pkg::job_t wr_job,
    output logic           full,
    input  logic           rd_en,
    output greg_pkg::job_t rd_job,
    output logic           nonempty
);

    greg_pkg::job_t mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    assign full     = (cnt_reg == 2'd2);
    assign nonempty = (cnt_reg != 2'd0);
    assign rd_job   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!wr_en && rd_en)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

### hw/rtl/greg_back.sv
// ---------------------------------------------------------------------------
// greg_back
// drains a report's live slots in order, one word per cycle if output has room
// ---------------------------------------------------------------------------
module greg_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  greg_pkg::job_t q_job,
    input  logic           q_valid,
    output logic           q_pop,
    output logic [1:0]     event_kind,
    output logic [3:0]     event_code,
    output logic           last_event,
    output logic           empty,
    input  logic           pop
);

    typedef struct packed {
        greg_pkg::ev_t ev;
        logic          last;
    } out_word_t;

    logic [greg_pkg::NUM_SLOTS-1:0] cur_mask_reg;
    greg_pkg::ev_t [greg_pkg::NUM_SLOTS-1:0] cur_ev_reg;
    logic       cur_vld_reg;

    out_word_t  out_mem_reg [2];
    logic       out_wr_ptr_reg;
    logic       out_rd_ptr_reg;
    logic [1:0] out_cnt_reg;
    logic [1:0] out_cnt_next;

    logic [3:0]                     sel_idx;
    logic [greg_pkg::NUM_SLOTS-1:0] rest;
    logic       emit;
    logic       done;
    logic       load;
    logic       rd;
    out_word_t  head;

    // lowest live slot goes first
    always_comb
    begin
        sel_idx = '0;
        for (int i = greg_pkg::NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (cur_mask_reg[i])
            begin
                sel_idx = 4'(i);
            end
        end
    end

    assign rest  = cur_mask_reg & ~(16'b1 << sel_idx);
    assign emit  = cur_vld_reg && (out_cnt_reg != 2'd2);
    assign done  = emit && (rest == '0);
    assign load  = q_valid && (!cur_vld_reg || done);
    assign q_pop = load;
    assign rd    = pop && !empty;

    always_comb
    begin
        out_cnt_next = out_cnt_reg;
        if (emit && !rd)
        begin
            out_cnt_next = out_cnt_reg + 2'd1;
        end
        else if (!emit && rd)
        begin
            out_cnt_next = out_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_ev_reg <= q_job.ev;
        end
        if (emit)
        begin
            out_mem_reg[out_wr_ptr_reg] <= '{ev: cur_ev_reg[sel_idx], last: (rest == '0)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_mask_reg   <= '0;
            cur_vld_reg    <= 1'b0;
            out_wr_ptr_reg <= 1'b0;
            out_rd_ptr_reg <= 1'b0;
            out_cnt_reg    <= '0;
        end
        else
        begin
            if (load)
            begin
                cur_mask_reg <= q_job.mask;
                cur_vld_reg  <= 1'b1;
            end
            else if (emit)
            begin
                cur_mask_reg <= rest;
                cur_vld_reg  <= !done;
            end
            if (emit)
            begin
                out_wr_ptr_reg <= !out_wr_ptr_reg;
            end
            if (rd)
            begin
                out_rd_ptr_reg <= !out_rd_ptr_reg;
            end
            out_cnt_reg <= out_cnt_next;
        end
    end

    assign head       = out_mem_reg[out_rd_ptr_reg];
    assign empty      = (out_cnt_reg == 2'd0);
    assign event_kind = head.ev.kind;
    assign event_code = head.ev.code;
    assign last_event = head.last;

endmodule

### hw/rtl/gamepad_report_event_generator_unit.sv
// a report's first event passes the job queue, current slot registers and output buffer
// throughput: reports are taken every cycle while the two-entry job queue has room
// the back end drains one event word per cycle while the output buffer has room
// reports that change nothing are absorbed in the push cycle and take no back end time
// reset: async, clears button, hat and stick history and both queues, loads register defaults
// ---------------------------------------------------------------------------
// gamepad_report_event_generator_unit
// turns gamepad reports into ordered press, release, hat and stick direction words
// ---------------------------------------------------------------------------
module gamepad_report_event_generator_unit
(
    input  logic       clk,
    input  logic       rst_n,

    // report side
    input  logic       push,
    output logic       full,
    input  logic [7:0] axis_x,
    input  logic [7:0] axis_y,
    input  logic [3:0] hat_value,
    input  logic [3:0] face_bits,
    input  logic [3:0] shoulder_bits,
    input  logic [1:0] start_bits,

    // event side
    output logic       empty,
    input  logic       pop,
    output logic [1:0] event_kind,
    output logic [3:0] event_code,
    output logic       last_event,

    // register writes
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);

    greg_pkg::cfg_t cfg_reg;
    greg_pkg::job_t front_job;
    greg_pkg::job_t q_job;
    logic           front_push;
    logic           accept;
    logic           q_valid;
    logic           q_pop;

    // register writes are always accepted, cfg_ready is tied high
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center     <= greg_pkg::CENTER_RESET;
            cfg_reg.deadband   <= greg_pkg::DEADBAND_RESET;
            cfg_reg.code_left  <= greg_pkg::CODE_LEFT_RESET;
            cfg_reg.code_right <= greg_pkg::CODE_RIGHT_RESET;
            cfg_reg.code_up    <= greg_pkg::CODE_UP_RESET;
            cfg_reg.code_down  <= greg_pkg::CODE_DOWN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (greg_pkg::cfg_idx_t'(cfg_index))
                greg_pkg::CFG_CENTER:     cfg_reg.center     <= cfg_data;
                greg_pkg::CFG_DEADBAND:   cfg_reg.deadband   <= cfg_data[6:0];
                greg_pkg::CFG_CODE_LEFT:  cfg_reg.code_left  <= cfg_data[2:0];
                greg_pkg::CFG_CODE_RIGHT: cfg_reg.code_right <= cfg_data[2:0];
                greg_pkg::CFG_CODE_UP:    cfg_reg.code_up    <= cfg_data[2:0];
                greg_pkg::CFG_CODE_DOWN:  cfg_reg.code_down  <= cfg_data[2:0];
                default:
                begin
                    // unmapped index, write is dropped
                end
            endcase
        end
    end

    // a report is taken whenever the job queue can hold its result
    assign accept = push && !full;

    // front: history compare and slot build
    greg_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .accept        (accept),
        .axis_x        (axis_x),
        .axis_y        (axis_y),
        .hat_value     (hat_value),
        .face_bits     (face_bits),
        .shoulder_bits (shoulder_bits),
        .start_bits    (start_bits),
        .job           (front_job),
        .job_push      (front_push)
    );

    // queue between front and back
    greg_job_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (front_push),
        .wr_job   (front_job),
        .full     (full),
        .rd_en    (q_pop),
        .rd_job   (q_job),
        .nonempty (q_valid)
    );

    // back: slot drain and output buffer
    greg_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_job      (q_job),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .event_kind (event_kind),
        .event_code (event_code),
        .last_event (last_event),
        .empty      (empty),
        .pop        (pop)
    );

endmodule

### hw/rtl/greg_checker.sv
// ---------------------------------------------------------------------------
// greg_checker
// port-level checks on the gamepad report event generator
// ---------------------------------------------------------------------------
`include "gamepad_report_event_generator_unit_assert.svh"

module greg_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [1:0] event_kind,
    input logic [3:0] event_code,
    input logic       last_event,
    input logic       cfg_ready
);

    // register writes never stall
    `GREG_ASSERT(a_cfg_ready, clk, rst_n, 1'b1, cfg_ready)

    // button words carry numbers 1 to 10
    `GREG_ASSERT(a_btn_code, clk, rst_n, !empty && !event_kind[1], event_code >= 4'd1 && event_code <= 4'd10)

    // direction words carry codes 0 to 7
    `GREG_ASSERT(a_dir_code, clk, rst_n, !empty && event_kind[1], !event_code[3])

    // a waiting word holds until taken
    `GREG_ASSERT_NEXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(event_kind) && $stable(event_code) && $stable(last_event))

endmodule

bind gamepad_report_event_generator_unit greg_checker u_greg_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .pop        (pop),
    .event_kind (event_kind),
    .event_code (event_code),
    .last_event (last_event),
    .cfg_ready  (cfg_ready)
);
